// ----- rtl/icl_pkg.sv -----
// ----------------------------------------------------------------------------
// icl_pkg
// Shared types and constants for the image cache LRU lookup block: entry
// layout, outcome codes and controller states.
// ----------------------------------------------------------------------------
package icl_pkg;

  localparam int ENTRIES_DEFAULT = 256;

  localparam int KEY_W   = 17;
  localparam int ATTR_W  = 16;
  localparam int HASH_W  = 64;
  localparam int STAMP_W = 32;
  localparam int ID_W    = 32;
  localparam int SLOT_W  = 8;
  localparam int OUTC_W  = 3;

  typedef enum logic [OUTC_W-1:0] {
    OUT_HIT    = 3'd0,
    OUT_REFILL = 3'd1,
    OUT_FILL   = 3'd2,
    OUT_EVICT  = 3'd3,
    OUT_TICK   = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [ATTR_W-1:0]  attr;
    logic [HASH_W-1:0]  hash;
    logic [STAMP_W-1:0] stamp;
    logic [ID_W-1:0]    id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/icl_req_if.sv -----
// ----------------------------------------------------------------------------
// icl_req_if
// Request channel: a frame tick or an image lookup, valid/ready handshake.
// ----------------------------------------------------------------------------
interface icl_req_if
  import icl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KEY_W-1:0]  image_key;
  logic [ATTR_W-1:0] attr_word;
  logic [HASH_W-1:0] content_hash;

  modport source (output valid, req_type, image_key, attr_word, content_hash,
                  input ready);
  modport sink   (input valid, req_type, image_key, attr_word, content_hash,
                  output ready);
endinterface

// ----- rtl/icl_res_if.sv -----
// ----------------------------------------------------------------------------
// icl_res_if
// Result channel: slot, outcome and image id, valid/ready handshake.
// ----------------------------------------------------------------------------
interface icl_res_if
  import icl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic [OUTC_W-1:0] outcome;
  logic [ID_W-1:0]   image_id;

  modport source (output valid, slot_index, outcome, image_id, input ready);
  modport sink   (input valid, slot_index, outcome, image_id, output ready);
endinterface

// ----- rtl/icl_ram.sv -----
// ----------------------------------------------------------------------------
// icl_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module icl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/image_cache_lru_lookup_core.sv -----
// ----------------------------------------------------------------------------
// image_cache_lru_lookup_core
// Fully associative LRU tag store for composed sprite images.
// ----------------------------------------------------------------------------
// A frame tick goes from acceptance through ST_DONE to a result in the output
// register, provided the output register is free. A lookup walks the filled
// entries of the tag RAM, one read per cycle through its single read port,
// and a lookup that matches stops early at the matching entry. N, the number
// of filled entries, is at most ENTRIES. Only one transaction is worked on at
// a time, but the next request is accepted while the previous result still
// waits in the output register. Entries are filled in ascending order and
// never freed, so the valid entries are always 0 .. N-1 and a fill count
// stands in for the per-entry valid bits; no clearing pass is needed after
// reset. During the walk the first entry matching key and attribute is looked
// for, and the entry with the smallest stamp (lowest index on ties) is tracked
// for eviction. Image ids start at 1 and wrap from all ones back to 1, so id 0
// is never issued.
// ----------------------------------------------------------------------------
module image_cache_lru_lookup_core
  import icl_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  icl_req_if.sink   req,
  icl_res_if.source res
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  state_t state, state_next;

  // Fill count: entries 0 .. fill_count-1 are valid.
  logic [CNT_W-1:0]   fill_count;
  logic [STAMP_W-1:0] frame_count;
  logic [ID_W-1:0]    id_counter;

  // Request being worked on.
  logic [KEY_W-1:0]  cur_key;
  logic [ATTR_W-1:0] cur_attr;
  logic [HASH_W-1:0] cur_hash;

  // Scan state: next address to read, and the read now in flight.
  logic [CNT_W-1:0] scan_addr;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;

  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic [HASH_W-1:0]  found_hash;
  logic [ID_W-1:0]    found_id;
  logic               have_min;
  logic [IDX_W-1:0]   min_idx;
  logic [STAMP_W-1:0] min_stamp;

  // Result held between the decision and the output register.
  logic [SLOT_W-1:0] res_slot;
  outcome_t          res_outcome;
  logic [ID_W-1:0]   res_id;

  entry_t rd_entry;
  logic [ENTRY_W-1:0] rd_word;
  entry_t wr_entry;

  logic accept;
  logic match_now;
  logic issue;
  logic out_free;

  // Decision for the lookup, valid in ST_DECIDE.
  logic [IDX_W-1:0] dec_slot;
  outcome_t         dec_outcome;
  logic [ID_W-1:0]  dec_id;
  logic             dec_take_id;
  logic             dec_grow;

  assign rd_entry = entry_t'(rd_word);

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !res.valid || res.ready;

  // The tag RAM output holds the entry addressed in the previous scan cycle.
  assign match_now = (state == ST_SCAN) && pend &&
                     (rd_entry.key == cur_key) && (rd_entry.attr == cur_attr);
  assign issue     = (state == ST_SCAN) && (scan_addr < fill_count) && !match_now;

  icl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (state == ST_DECIDE),
    .waddr (dec_slot),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (scan_addr[IDX_W-1:0]),
    .rdata (rd_word)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = req.req_type ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (match_now || (!issue && !pend)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Decision: hit, refill in place, fill the next empty slot, or evict the oldest.
  always_comb begin
    dec_slot    = found_idx;
    dec_outcome = OUT_HIT;
    dec_id      = found_id;
    dec_take_id = 1'b0;
    dec_grow    = 1'b0;
    if (found) begin
      if (found_hash != cur_hash) begin
        dec_outcome = OUT_REFILL;
        dec_id      = id_counter;
        dec_take_id = 1'b1;
      end
    end else if (fill_count < CNT_W'(ENTRIES)) begin
      dec_slot    = fill_count[IDX_W-1:0];
      dec_outcome = OUT_FILL;
      dec_id      = id_counter;
      dec_take_id = 1'b1;
      dec_grow    = 1'b1;
    end else begin
      dec_slot    = min_idx;
      dec_outcome = OUT_EVICT;
      dec_id      = id_counter;
      dec_take_id = 1'b1;
    end
    // On a hit the stored hash equals the request hash, so one write form serves all.
    wr_entry.key   = cur_key;
    wr_entry.attr  = cur_attr;
    wr_entry.hash  = cur_hash;
    wr_entry.stamp = frame_count;
    wr_entry.id    = dec_id;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_count  <= '0;
      frame_count <= '0;
      id_counter  <= ID_W'(1);
      pend        <= 1'b0;
      found       <= 1'b0;
      have_min    <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        pend     <= 1'b0;
        found    <= 1'b0;
        have_min <= 1'b0;
        if (!req.req_type) begin
          frame_count <= frame_count + 1'b1;
        end
      end

      if (state == ST_SCAN) begin
        pend <= issue;
        if (match_now) begin
          found <= 1'b1;
        end else if (pend) begin
          have_min <= 1'b1;
        end
      end

      if (state == ST_DECIDE) begin
        if (dec_take_id) begin
          id_counter <= (id_counter == '1) ? ID_W'(1) : id_counter + 1'b1;
        end
        if (dec_grow) begin
          fill_count <= fill_count + 1'b1;
        end
      end

      if (state == ST_DONE && out_free) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_key   <= req.image_key;
      cur_attr  <= req.attr_word;
      cur_hash  <= req.content_hash;
      scan_addr <= '0;
      if (!req.req_type) begin
        res_slot    <= '0;
        res_outcome <= OUT_TICK;
        res_id      <= '0;
      end
    end

    if (state == ST_SCAN) begin
      pend_idx <= scan_addr[IDX_W-1:0];
      if (issue) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (match_now) begin
        found_idx  <= pend_idx;
        found_hash <= rd_entry.hash;
        found_id   <= rd_entry.id;
      end else if (pend && (!have_min || rd_entry.stamp < min_stamp)) begin
        // Strict compare keeps the lowest index on equal stamps.
        min_idx   <= pend_idx;
        min_stamp <= rd_entry.stamp;
      end
    end

    if (state == ST_DECIDE) begin
      res_slot    <= SLOT_W'(dec_slot);
      res_outcome <= dec_outcome;
      res_id      <= dec_id;
    end

    if (state == ST_DONE && out_free) begin
      res.slot_index <= res_slot;
      res.outcome    <= res_outcome;
      res.image_id   <= res_id;
    end
  end

endmodule

// ----- rtl/icl_checker.sv -----
// ----------------------------------------------------------------------------
// icl_checker
// Port-level checks for the image cache LRU lookup block, bound to the top.
// ----------------------------------------------------------------------------
module icl_checker
  import icl_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [SLOT_W-1:0] slot_index,
  input logic [OUTC_W-1:0] outcome,
  input logic [ID_W-1:0]   image_id
);

  // Transactions accepted but not yet answered.
  logic [1:0] open_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_count <= '0;
    end else begin
      open_count <= open_count + 2'(req_valid && req_ready) - 2'(res_valid && res_ready);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid directly after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> open_count != 2'd0)
    else $error("result without an open request");

  a_ready_bound: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> open_count <= 2'd1)
    else $error("request accepted with two results outstanding");

  a_tick_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && outcome == OUT_TICK) |-> (slot_index == '0 && image_id == '0))
    else $error("tick result with non-zero slot or id");

  a_lookup_id: assert property (@(posedge clk) disable iff (rst)
    (res_valid && outcome != OUT_TICK) |-> image_id != '0)
    else $error("lookup result with image id zero");

endmodule

bind image_cache_lru_lookup_core icl_checker u_icl_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .slot_index (res.slot_index),
  .outcome    (res.outcome),
  .image_id   (res.image_id)
);

// ----- dv/image_cache_lru_lookup_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_cache_lru_lookup_core_test
// Self-checking bench for the image cache LRU lookup core. A short table of
// hand-picked requests opens the run, followed by a long stretch of random
// frame ticks and lookups aimed at hits, refills, fills and evictions. Every
// result is checked against a hand-written row or a behavioural tag store.
// ----------------------------------------------------------------------------
module image_cache_lru_lookup_core_test;
  import icl_pkg::*;

  localparam int SLOTS        = 256;
  localparam int RANDOM_ITEMS = 1950;
  // Covers a full scan of all SLOTS entries plus the longest gap and stall,
  // with a generous margin on top.
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
  localparam int MAX_WAIT     = 13;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    bit              is_lookup;
    bit [KEY_W-1:0]  key;
    bit [ATTR_W-1:0] attr;
    bit [HASH_W-1:0] hash;
  } lookup_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    outcome_t          outc;
    logic [ID_W-1:0]   id;
  } lookup_result_t;

  // One row of the opening table. Where typed is set, the expected result is
  // written out by hand; otherwise the behavioural tag store supplies it.
  typedef struct {
    lookup_req_t    rq;
    bit             typed;
    lookup_result_t res;
  } directed_row_t;

  logic clk;
  logic rst;

  icl_req_if req_ch ();
  icl_res_if res_ch ();

  image_cache_lru_lookup_core #(
    .ENTRIES(SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // --------------------------------------------------------------------------
  // Behavioural tag store. Entries fill in ascending order and are never
  // freed, so the filled entries are always 0 .. filled_n-1.
  // --------------------------------------------------------------------------
  bit              tag_valid [SLOTS];
  bit [KEY_W-1:0]  tag_key   [SLOTS];
  bit [ATTR_W-1:0] tag_attr  [SLOTS];
  bit [HASH_W-1:0] tag_hash  [SLOTS];
  bit [31:0]       tag_stamp [SLOTS];
  bit [ID_W-1:0]   tag_id    [SLOTS];
  bit [31:0]       frame_count;
  bit [ID_W-1:0]   next_image_id;
  int              filled_n;

  lookup_result_t  pending_results [$];

  // Recently seen key/attribute pairs, so that evicted images come back.
  bit [KEY_W-1:0]  recent_key  [$];
  bit [ATTR_W-1:0] recent_attr [$];

  int sent_n, checked_n, mismatch_n;
  int hit_n, refill_n, fill_n, evict_n, tick_n;
  bit src_burst, sink_burst;

  // Writes a whole entry and hands out the next image id. The id counter
  // skips zero when it wraps.
  function automatic void store_entry(input int slot, input lookup_req_t rq);
    tag_valid[slot] = 1'b1;
    tag_key[slot]   = rq.key;
    tag_attr[slot]  = rq.attr;
    tag_hash[slot]  = rq.hash;
    tag_stamp[slot] = frame_count;
    tag_id[slot]    = next_image_id;
    next_image_id   = (next_image_id == '1) ? ID_W'(1) : next_image_id + 1'b1;
  endfunction

  function automatic lookup_result_t predict_lookup(input lookup_req_t rq);
    lookup_result_t rs;
    int  slot;
    bit  found;
    bit  empty;
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;
    rs.slot = '0;
    rs.id   = '0;
    rs.outc = OUT_TICK;
    if (!rq.is_lookup) begin
      frame_count = frame_count + 1'b1;
      tick_n++;
      return rs;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && tag_valid[i] && tag_key[i] == rq.key && tag_attr[i] == rq.attr) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (tag_hash[slot] == rq.hash) begin
        tag_stamp[slot] = frame_count;
        rs.outc = OUT_HIT;
        hit_n++;
      end else begin
        store_entry(slot, rq);
        rs.outc = OUT_REFILL;
        refill_n++;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!empty && !tag_valid[i]) begin
          slot  = i;
          empty = 1'b1;
        end
      end
      if (empty) begin
        rs.outc = OUT_FILL;
        filled_n++;
        fill_n++;
      end else begin
        // Oldest stamp wins; a strict compare keeps the lowest index on ties.
        slot = 0;
        for (int i = 1; i < SLOTS; i++)
          if (tag_stamp[i] < tag_stamp[slot])
            slot = i;
        rs.outc = OUT_EVICT;
        evict_n++;
      end
      store_entry(slot, rq);
    end
    rs.slot = slot[SLOT_W-1:0];
    rs.id   = tag_id[slot];
    return rs;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; a transaction is taken
  // as accepted at the rising edge where valid and ready are both high, and
  // that is also the moment the expected result is worked out.
  // --------------------------------------------------------------------------
  task automatic send_request(input lookup_req_t rq, input bit typed,
                              input lookup_result_t typed_res);
    int gap;
    lookup_result_t predicted;
    gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rq.is_lookup;
    req_ch.image_key    <= rq.key;
    req_ch.attr_word    <= rq.attr;
    req_ch.content_hash <= rq.hash;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_lookup(rq);
    pending_results.push_back(typed ? typed_res : predicted);
    sent_n++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: a random stall before each transaction, then a field by
  // field compare with the oldest expectation.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    lookup_result_t want;
    int stall;
    res_ch.ready = 1'b0;
    sink_burst   = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (checked_n % 50 == 0)
        sink_burst = ($urandom_range(0, 3) == 0);
      stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (stall) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      checked_n++;
      if (pending_results.size() == 0) begin
        mismatch_n++;
        if (mismatch_n <= REPORT_MAX)
          $display("%0t: unexpected result slot=%0d outcome=%0d id=%0d", $realtime,
                   res_ch.slot_index, res_ch.outcome, res_ch.image_id);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.slot_index !== want.slot || res_ch.outcome !== want.outc ||
            res_ch.image_id !== want.id) begin
          mismatch_n++;
          if (mismatch_n <= REPORT_MAX)
            $display("%0t: result %0d expected slot=%0d outcome=%0d id=%0d, got slot=%0d outcome=%0d id=%0d",
                     $realtime, checked_n, want.slot, want.outc, want.id,
                     res_ch.slot_index, res_ch.outcome, res_ch.image_id);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when neither channel moves a transaction for too
  // long.
  // --------------------------------------------------------------------------
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    directed_row_t rows [$];
    lookup_req_t    rq;
    lookup_result_t none;
    int pick, r;

    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = 1'b0;
    req_ch.image_key    = '0;
    req_ch.attr_word    = '0;
    req_ch.content_hash = '0;
    frame_count         = '0;
    next_image_id       = ID_W'(1);
    filled_n            = 0;
    src_burst           = 1'b0;
    none.slot = '0;
    none.outc = OUT_TICK;
    none.id   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_key[i]   = '0;
      tag_attr[i]  = '0;
      tag_hash[i]  = '0;
      tag_stamp[i] = '0;
      tag_id[i]    = '0;
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Opening table. The first rows follow the empty store step by step: a
    // tick with every other field set (which must be ignored), a first fill,
    // a hit, a refill in place, the all-ones key/attribute/hash corner, the
    // same key under a different attribute, and a hit that survives a tick.
    rows.push_back('{'{1'b0, 17'h1FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF},
                     1'b1, '{8'd0, OUT_TICK, 32'd0}});
    rows.push_back('{'{1'b1, 17'h00000, 16'h0000, 64'h0}, 1'b1, '{8'd0, OUT_FILL, 32'd1}});
    rows.push_back('{'{1'b1, 17'h00000, 16'h0000, 64'h0}, 1'b1, '{8'd0, OUT_HIT, 32'd1}});
    rows.push_back('{'{1'b1, 17'h00000, 16'h0000, 64'h1}, 1'b1, '{8'd0, OUT_REFILL, 32'd2}});
    rows.push_back('{'{1'b1, 17'h1FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF},
                     1'b1, '{8'd1, OUT_FILL, 32'd3}});
    rows.push_back('{'{1'b1, 17'h1FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF},
                     1'b1, '{8'd1, OUT_HIT, 32'd3}});
    rows.push_back('{'{1'b1, 17'h1FFFF, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF},
                     1'b1, '{8'd2, OUT_FILL, 32'd4}});
    rows.push_back('{'{1'b1, 17'h00000, 16'hFFFF, 64'h0}, 1'b1, '{8'd3, OUT_FILL, 32'd5}});
    rows.push_back('{'{1'b0, 17'h00000, 16'h0000, 64'h0}, 1'b1, '{8'd0, OUT_TICK, 32'd0}});
    rows.push_back('{'{1'b1, 17'h00000, 16'h0000, 64'h1}, 1'b1, '{8'd0, OUT_HIT, 32'd2}});
    // From here the tag store predicts: a sprite-size key, alternating bit
    // patterns, a hash with every bit inverted and refreshed stamps after ticks.
    rows.push_back('{'{1'b1, 17'h10040, 16'h8001, 64'h8000_0000_0000_0001}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h0FFFF, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h0AAAA, 16'hAAAA, 64'h5555_5555_5555_5555}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h10040, 16'h8001, 64'h7FFF_FFFF_FFFF_FFFE}, 1'b0, none});
    rows.push_back('{'{1'b0, 17'h15555, 16'h5555, 64'h5555_5555_5555_5555}, 1'b0, none});
    rows.push_back('{'{1'b0, 17'h0AAAA, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h1FFFF, 16'hFFFF, 64'h0}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h1FFFF, 16'hFFFF, 64'h0}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h0FFFF, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h100FF, 16'h0001, 64'h0000_0001_0000_0000}, 1'b0, none});
    rows.push_back('{'{1'b1, 17'h10000, 16'h8000, 64'h1234_5678_9ABC_DEF0}, 1'b0, none});

    foreach (rows[i])
      send_request(rows[i].rq, rows[i].typed, rows[i].res);

    // Random part. Most lookups revisit entries that are in the store, so
    // that hits and refills keep coming; fresh keys push the store past full
    // and keep evictions going, and ticks age the stamps in between.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0)
        src_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      rq.is_lookup = 1'b1;
      rq.key       = KEY_W'($urandom_range(0, 17'h1FFFF));
      rq.attr      = ATTR_W'($urandom_range(0, 16'hFFFF));
      rq.hash      = {$urandom, $urandom};
      if (r < 18) begin
        // Tick with random rubbish in the ignored fields.
        rq.is_lookup = 1'b0;
      end else if (r < 62 && filled_n > 0) begin
        pick    = $urandom_range(0, filled_n - 1);
        rq.key  = tag_key[pick];
        rq.attr = tag_attr[pick];
        if (r < 50)
          rq.hash = tag_hash[pick];
        else if (r < 56)
          rq.hash = tag_hash[pick] ^ (64'd1 << $urandom_range(0, 63));
      end else if (r < 72 && recent_key.size() > 0) begin
        // An image seen earlier, possibly evicted since.
        pick    = $urandom_range(0, recent_key.size() - 1);
        rq.key  = recent_key[pick];
        rq.attr = recent_attr[pick];
      end else begin
        case ($urandom_range(0, 3))
          0: rq.key = {1'b1, 8'h00, 8'($urandom_range(0, 255))};
          1: rq.attr = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
          2: rq.hash = ($urandom_range(0, 1) == 0) ? 64'h0 : '1;
          default: ;
        endcase
        recent_key.push_back(rq.key);
        recent_attr.push_back(rq.attr);
        if (recent_key.size() > 64) begin
          void'(recent_key.pop_front());
          void'(recent_attr.pop_front());
        end
      end
      send_request(rq, 1'b0, none);
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d results: %0d hits, %0d refills, %0d fills,",
             sent_n, checked_n, hit_n, refill_n, fill_n);
    $display("%0d evictions and %0d frame ticks; %0d mismatches.", evict_n, tick_n, mismatch_n);
    if (mismatch_n == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
